// ===== sv/btt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// btt_pkg: types, register indexes and reset values for the button scanner.
// Used by btt_cfg, btt_core and the top level; depends on nothing.
package btt_pkg;

    typedef enum logic [2:0] {
        REG_PRESS_THR      = 3'd0,
        REG_GAP_THR        = 3'd1,
        REG_TAP_THR        = 3'd2,
        REG_HOLD_UNIT_THR  = 3'd3,
        REG_HOLD_UNITS_THR = 3'd4
    } reg_idx_t;

    localparam logic [7:0] PRESS_THR_RST      = 8'd5;
    localparam logic [7:0] GAP_THR_RST        = 8'd50;
    localparam logic [2:0] TAP_THR_RST        = 3'd2;
    localparam logic [7:0] HOLD_UNIT_THR_RST  = 8'd100;
    localparam logic [3:0] HOLD_UNITS_THR_RST = 4'd2;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_PAIRING = 2'd1;
    localparam logic [1:0] CMD_STATUS  = 2'd2;

    localparam logic [1:0] LEN_SHORT  = 2'd1;
    localparam logic [1:0] LEN_STATUS = 2'd2;

    localparam logic [1:0] PAIR_NONE   = 2'd1;
    localparam logic [1:0] PAIR_OK     = 2'd2;
    localparam logic [1:0] RESET_DONE  = 2'd3;

    typedef struct packed {
        logic [7:0] press_thr;
        logic [7:0] gap_thr;
        logic [2:0] tap_thr;
        logic [7:0] hold_unit_thr;
        logic [3:0] hold_units_thr;
    } cfg_t;

    typedef struct packed {
        logic       key_down;
        logic [1:0] switch_now;
        logic [7:0] id_byte_one;
        logic [7:0] id_byte_two;
        logic [7:0] id_byte_three;
        logic [7:0] id_byte_four;
        logic [7:0] sum_byte_first;
        logic [7:0] sum_byte_second;
    } item_t;

    typedef struct packed {
        logic [1:0] switch_next;
        logic       clear_id;
        logic       reply_valid;
        logic [1:0] reply_cmd;
        logic [1:0] reply_len;
        logic [1:0] opt_zero;
        logic [7:0] opt_one;
        logic [7:0] opt_two;
        logic [7:0] opt_three;
        logic [7:0] opt_four;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/btt_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// btt_cfg: threshold registers behind the plain write port.
// Depends on btt_pkg.
module btt_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    output btt_pkg::cfg_t      cfg
);

    btt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_thr      <= btt_pkg::PRESS_THR_RST;
            cfg_reg.gap_thr        <= btt_pkg::GAP_THR_RST;
            cfg_reg.tap_thr        <= btt_pkg::TAP_THR_RST;
            cfg_reg.hold_unit_thr  <= btt_pkg::HOLD_UNIT_THR_RST;
            cfg_reg.hold_units_thr <= btt_pkg::HOLD_UNITS_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                btt_pkg::REG_PRESS_THR:      cfg_reg.press_thr      <= cfg_data;
                btt_pkg::REG_GAP_THR:        cfg_reg.gap_thr        <= cfg_data;
                btt_pkg::REG_TAP_THR:        cfg_reg.tap_thr        <= cfg_data[2:0];
                btt_pkg::REG_HOLD_UNIT_THR:  cfg_reg.hold_unit_thr  <= cfg_data;
                btt_pkg::REG_HOLD_UNITS_THR: cfg_reg.hold_units_thr <= cfg_data[3:0];
                default:                     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== sv/btt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// btt_core: scanner state (debounce, tap, hold counters, arming) and the
// per-tick result logic. Depends on btt_pkg.
module btt_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire btt_pkg::cfg_t   cfg,
    input  wire btt_pkg::item_t  item,
    output btt_pkg::result_t     res
);

    logic [7:0] press_timer_reg, press_timer_next;
    logic       press_latched_reg, press_latched_next;
    logic [7:0] tap_timer_reg, tap_timer_next;
    logic       tap_latched_reg, tap_latched_next;
    logic [3:0] tap_count_reg, tap_count_next;
    logic [7:0] gap_timer_reg, gap_timer_next;
    logic       armed_reg, armed_next;
    logic [7:0] hold_fine_reg, hold_fine_next;
    logic [3:0] hold_coarse_reg, hold_coarse_next;
    logic       clear_pending_reg, clear_pending_next;

    always_comb
    begin
        logic [1:0] sw;
        logic       paired;

        press_timer_next   = press_timer_reg;
        press_latched_next = press_latched_reg;
        tap_timer_next     = tap_timer_reg;
        tap_latched_next   = tap_latched_reg;
        tap_count_next     = tap_count_reg;
        gap_timer_next     = gap_timer_reg;
        armed_next         = armed_reg;
        hold_fine_next     = hold_fine_reg;
        hold_coarse_next   = hold_coarse_reg;
        clear_pending_next = clear_pending_reg;

        sw     = item.switch_now;
        paired = |{item.id_byte_one, item.id_byte_two, item.id_byte_three, item.id_byte_four};
        res    = '0;

        if (armed_reg)
        begin
            // debounced press
            if (item.key_down)
            begin
                if (!press_latched_reg)
                begin
                    press_timer_next = press_timer_reg + 8'd1;
                    if (press_timer_next > cfg.press_thr)
                    begin
                        press_timer_next   = '0;
                        press_latched_next = 1'b1;
                        sw = (sw != 2'd0) ? 2'd0 : 2'd3;
                        res.reply_valid = 1'b1;
                        res.reply_cmd   = btt_pkg::CMD_STATUS;
                        res.reply_len   = btt_pkg::LEN_STATUS;
                        res.opt_zero    = sw;
                        res.opt_two     = item.sum_byte_first;
                        res.opt_three   = item.sum_byte_second;
                    end
                end
            end
            else
            begin
                press_timer_next   = '0;
                press_latched_next = 1'b0;
            end

            // tap counting
            if (item.key_down)
            begin
                gap_timer_next = '0;
                tap_timer_next = tap_timer_reg + 8'd1;
                if (tap_timer_next > cfg.press_thr)
                begin
                    tap_timer_next = '0;
                    if (!tap_latched_reg)
                    begin
                        tap_latched_next = 1'b1;
                        tap_count_next   = tap_count_reg + 4'd1;
                    end
                end
            end
            else
            begin
                tap_timer_next   = '0;
                tap_latched_next = 1'b0;
                gap_timer_next   = gap_timer_reg + 8'd1;
                if (gap_timer_next > cfg.gap_thr)
                begin
                    gap_timer_next = '0;
                    tap_count_next = '0;
                end
                if (tap_count_next > {1'b0, cfg.tap_thr})
                begin
                    tap_count_next  = '0;
                    res.reply_valid = 1'b1;
                    res.reply_cmd   = btt_pkg::CMD_PAIRING;
                    res.reply_len   = btt_pkg::LEN_SHORT;
                    res.opt_zero    = paired ? btt_pkg::PAIR_OK : btt_pkg::PAIR_NONE;
                    res.opt_one     = item.id_byte_one;
                    res.opt_two     = item.id_byte_two;
                    res.opt_three   = item.id_byte_three;
                    res.opt_four    = item.id_byte_four;
                end
            end

            // pending identity clear
            if (clear_pending_reg)
            begin
                clear_pending_next = 1'b0;
                res.clear_id    = 1'b1;
                res.reply_valid = 1'b1;
                res.reply_cmd   = btt_pkg::CMD_PAIRING;
                res.reply_len   = btt_pkg::LEN_SHORT;
                res.opt_zero    = btt_pkg::RESET_DONE;
                res.opt_one     = '0;
                res.opt_two     = '0;
                res.opt_three   = '0;
                res.opt_four    = '0;
            end
        end
        else
        begin
            if (item.key_down)
            begin
                hold_fine_next = hold_fine_reg + 8'd1;
                if (hold_fine_next > cfg.hold_unit_thr)
                begin
                    hold_fine_next   = '0;
                    hold_coarse_next = hold_coarse_reg + 4'd1;
                    if (hold_coarse_next > cfg.hold_units_thr)
                    begin
                        hold_coarse_next   = '0;
                        clear_pending_next = 1'b1;
                        armed_next         = 1'b1;
                    end
                end
            end
            else
            begin
                armed_next = 1'b1;
            end
        end

        res.switch_next = sw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_timer_reg   <= '0;
            press_latched_reg <= 1'b0;
            tap_timer_reg     <= '0;
            tap_latched_reg   <= 1'b0;
            tap_count_reg     <= '0;
            gap_timer_reg     <= '0;
            armed_reg         <= 1'b0;
            hold_fine_reg     <= '0;
            hold_coarse_reg   <= '0;
            clear_pending_reg <= 1'b0;
        end
        else if (step)
        begin
            press_timer_reg   <= press_timer_next;
            press_latched_reg <= press_latched_next;
            tap_timer_reg     <= tap_timer_next;
            tap_latched_reg   <= tap_latched_next;
            tap_count_reg     <= tap_count_next;
            gap_timer_reg     <= gap_timer_next;
            armed_reg         <= armed_next;
            hold_fine_reg     <= hold_fine_next;
            hold_coarse_reg   <= hold_coarse_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/button_toggle_tap_pair_hold_reset.sv =====
`timescale 1ns / 1ps
// Button scanner top level: input register, btt_core step logic, result register.
// Taken ticks wait in the single input register while the single result register
// is full and unread. Throughput: one tick per cycle while out_ready is high.
// Reset: all counters and flags clear, block unarmed, thresholds at defaults.
// Depends on btt_pkg, btt_cfg, btt_core.
`default_nettype none
module button_toggle_tap_pair_hold_reset (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       key_down,
    input  wire logic [1:0] switch_now,
    input  wire logic [7:0] id_byte_one,
    input  wire logic [7:0] id_byte_two,
    input  wire logic [7:0] id_byte_three,
    input  wire logic [7:0] id_byte_four,
    input  wire logic [7:0] sum_byte_first,
    input  wire logic [7:0] sum_byte_second,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      switch_next,
    output logic            clear_id,
    output logic            reply_valid,
    output logic [1:0]      reply_cmd,
    output logic [1:0]      reply_len,
    output logic [1:0]      opt_zero,
    output logic [7:0]      opt_one,
    output logic [7:0]      opt_two,
    output logic [7:0]      opt_three,
    output logic [7:0]      opt_four
);

    btt_pkg::cfg_t    cfg;
    btt_pkg::item_t   item_reg;
    btt_pkg::result_t res;
    btt_pkg::result_t res_reg;
    logic             item_valid_reg;
    logic             res_valid_reg;
    logic             advance;

    assign advance  = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    btt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    btt_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cfg   (cfg),
        .item  (item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.key_down        <= key_down;
            item_reg.switch_now      <= switch_now;
            item_reg.id_byte_one     <= id_byte_one;
            item_reg.id_byte_two     <= id_byte_two;
            item_reg.id_byte_three   <= id_byte_three;
            item_reg.id_byte_four    <= id_byte_four;
            item_reg.sum_byte_first  <= sum_byte_first;
            item_reg.sum_byte_second <= sum_byte_second;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = res_valid_reg;
    assign switch_next = res_reg.switch_next;
    assign clear_id    = res_reg.clear_id;
    assign reply_valid = res_reg.reply_valid;
    assign reply_cmd   = res_reg.reply_cmd;
    assign reply_len   = res_reg.reply_len;
    assign opt_zero    = res_reg.opt_zero;
    assign opt_one     = res_reg.opt_one;
    assign opt_two     = res_reg.opt_two;
    assign opt_three   = res_reg.opt_three;
    assign opt_four    = res_reg.opt_four;

endmodule
`default_nettype wire

// ===== tb/button_toggle_tap_pair_hold_reset_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the button scanner: debounce toggle, tap pairing query and
// power-up hold clear. Needs btt_pkg and the button_toggle_tap_pair_hold_reset RTL.
module button_toggle_tap_pair_hold_reset_test;
    import btt_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 430;

    class key_scanner;
        cfg_t       thr;
        logic [7:0] press_timer, tap_timer, gap_timer, hold_fine;
        logic [3:0] tap_count, hold_coarse;
        logic       press_latched, tap_latched, armed, clear_pending;
        result_t    due_replies[$];
        int         mismatches, status_due, pairing_due, clears_due;

        function new();
            thr.press_thr      = PRESS_THR_RST;
            thr.gap_thr        = GAP_THR_RST;
            thr.tap_thr        = TAP_THR_RST;
            thr.hold_unit_thr  = HOLD_UNIT_THR_RST;
            thr.hold_units_thr = HOLD_UNITS_THR_RST;
            {press_timer, tap_timer, gap_timer, hold_fine} = '0;
            {tap_count, hold_coarse} = '0;
            {press_latched, tap_latched, armed, clear_pending} = '0;
            mismatches  = 0;
            status_due  = 0;
            pairing_due = 0;
            clears_due  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [7:0] val);
            case (idx)
                REG_PRESS_THR:      thr.press_thr = val;
                REG_GAP_THR:        thr.gap_thr = val;
                REG_TAP_THR:        thr.tap_thr = val[2:0];
                REG_HOLD_UNIT_THR:  thr.hold_unit_thr = val;
                REG_HOLD_UNITS_THR: thr.hold_units_thr = val[3:0];
                default: ;
            endcase
        endfunction

        function void tick_taken(item_t t);
            result_t    r;
            logic [1:0] sw;
            logic       paired;
            r = '0;
            sw = t.switch_now;
            if (armed) begin
                if (t.key_down) begin
                    if (!press_latched) begin
                        press_timer = press_timer + 8'd1;
                        if (press_timer > thr.press_thr) begin
                            press_timer = '0;
                            press_latched = 1'b1;
                            sw = (sw != 2'd0) ? 2'd0 : 2'd3;
                            {r.reply_valid, r.reply_cmd, r.reply_len, r.opt_zero, r.opt_one,
                             r.opt_two, r.opt_three, r.opt_four} =
                                {1'b1, CMD_STATUS, LEN_STATUS, sw, 8'd0,
                                 t.sum_byte_first, t.sum_byte_second, 8'd0};
                        end
                    end
                end else begin
                    press_timer = '0;
                    press_latched = 1'b0;
                end

                if (t.key_down) begin
                    gap_timer = '0;
                    tap_timer = tap_timer + 8'd1;
                    if (tap_timer > thr.press_thr) begin
                        tap_timer = '0;
                        if (!tap_latched) begin
                            tap_latched = 1'b1;
                            tap_count = tap_count + 4'd1;
                        end
                    end
                end else begin
                    tap_timer = '0;
                    tap_latched = 1'b0;
                    gap_timer = gap_timer + 8'd1;
                    if (gap_timer > thr.gap_thr) begin
                        gap_timer = '0;
                        tap_count = '0;
                    end
                    if (tap_count > {1'b0, thr.tap_thr}) begin
                        paired = |{t.id_byte_one, t.id_byte_two, t.id_byte_three,
                                   t.id_byte_four};
                        tap_count = '0;
                        {r.reply_valid, r.reply_cmd, r.reply_len, r.opt_zero, r.opt_one,
                         r.opt_two, r.opt_three, r.opt_four} =
                            {1'b1, CMD_PAIRING, LEN_SHORT, paired ? PAIR_OK : PAIR_NONE,
                             t.id_byte_one, t.id_byte_two, t.id_byte_three, t.id_byte_four};
                    end
                end

                if (clear_pending) begin
                    clear_pending = 1'b0;
                    r.clear_id = 1'b1;
                    {r.reply_valid, r.reply_cmd, r.reply_len, r.opt_zero, r.opt_one,
                     r.opt_two, r.opt_three, r.opt_four} =
                        {1'b1, CMD_PAIRING, LEN_SHORT, RESET_DONE, 32'd0};
                end
            end else begin
                if (t.key_down) begin
                    hold_fine = hold_fine + 8'd1;
                    if (hold_fine > thr.hold_unit_thr) begin
                        hold_fine = '0;
                        hold_coarse = hold_coarse + 4'd1;
                        if (hold_coarse > thr.hold_units_thr) begin
                            hold_coarse = '0;
                            clear_pending = 1'b1;
                            armed = 1'b1;
                        end
                    end
                end else begin
                    armed = 1'b1;
                end
            end
            r.switch_next = sw;
            if (r.clear_id)
                clears_due++;
            else if (r.reply_valid && r.reply_cmd == CMD_STATUS)
                status_due++;
            else if (r.reply_valid)
                pairing_due++;
            due_replies.push_back(r);
        endfunction

        function void field_check(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void reply_seen(result_t got);
            result_t want;
            if (due_replies.size() == 0) begin
                $error("result transfer with no tick outstanding");
                mismatches++;
                return;
            end
            want = due_replies.pop_front();
            field_check("switch_next", want.switch_next, got.switch_next);
            field_check("clear_id", want.clear_id, got.clear_id);
            field_check("reply_valid", want.reply_valid, got.reply_valid);
            field_check("reply_cmd", want.reply_cmd, got.reply_cmd);
            field_check("reply_len", want.reply_len, got.reply_len);
            field_check("opt_zero", want.opt_zero, got.opt_zero);
            field_check("opt_one", want.opt_one, got.opt_one);
            field_check("opt_two", want.opt_two, got.opt_two);
            field_check("opt_three", want.opt_three, got.opt_three);
            field_check("opt_four", want.opt_four, got.opt_four);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    reg_idx_t   cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    item_t      tick_drv;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] switch_next;
    logic       clear_id;
    logic       reply_valid;
    logic [1:0] reply_cmd;
    logic [1:0] reply_len;
    logic [1:0] opt_zero;
    logic [7:0] opt_one;
    logic [7:0] opt_two;
    logic [7:0] opt_three;
    logic [7:0] opt_four;
    result_t    reply_bus;

    key_scanner scanner;
    logic [31:0] held_id;
    bit          no_stall = 1'b0;
    int          quiet_cycles = 0;
    int          ticks_sent = 0;
    int          settings_run = 0;

    assign reply_bus = {switch_next, clear_id, reply_valid, reply_cmd, reply_len, opt_zero,
                        opt_one, opt_two, opt_three, opt_four};

    button_toggle_tap_pair_hold_reset dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .key_down        (tick_drv.key_down),
        .switch_now      (tick_drv.switch_now),
        .id_byte_one     (tick_drv.id_byte_one),
        .id_byte_two     (tick_drv.id_byte_two),
        .id_byte_three   (tick_drv.id_byte_three),
        .id_byte_four    (tick_drv.id_byte_four),
        .sum_byte_first  (tick_drv.sum_byte_first),
        .sum_byte_second (tick_drv.sum_byte_second),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .switch_next     (switch_next),
        .clear_id        (clear_id),
        .reply_valid     (reply_valid),
        .reply_cmd       (reply_cmd),
        .reply_len       (reply_len),
        .opt_zero        (opt_zero),
        .opt_one         (opt_one),
        .opt_two         (opt_two),
        .opt_three       (opt_three),
        .opt_four        (opt_four)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                scanner.tick_taken(tick_drv);
            if (out_valid && out_ready)
                scanner.reply_seen(reply_bus);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(item_t t);
        int hold;
        hold = no_stall ? 0 : idle_gap();
        @(negedge clk);
        if (hold != 0)
        begin
            in_valid <= 1'b0;
            repeat (hold) @(negedge clk);
        end
        tick_drv <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // one press of down_len ticks followed by up_len released ticks
    task automatic key_cycle(int down_len, int up_len);
        logic [1:0] sw;
        item_t      t;
        sw = 2'($urandom_range(0, 3));
        for (int i = 0; i < down_len + up_len; i++)
        begin
            t.key_down = (i < down_len);
            t.switch_now = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : sw;
            {t.id_byte_one, t.id_byte_two, t.id_byte_three, t.id_byte_four} = held_id;
            t.sum_byte_first = 8'($urandom);
            t.sum_byte_second = 8'($urandom);
            send_tick(t);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scanner.due_replies.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        scanner.set_reg(idx, val);
    endtask

    task automatic set_thresholds(logic [7:0] press, logic [7:0] gap, logic [2:0] taps,
                                  logic [7:0] hold_unit, logic [3:0] hold_units);
        settle();
        write_reg(REG_PRESS_THR, press);
        write_reg(REG_GAP_THR, gap);
        write_reg(REG_TAP_THR, {5'd0, taps});
        write_reg(REG_HOLD_UNIT_THR, hold_unit);
        write_reg(REG_HOLD_UNITS_THR, {4'd0, hold_units});
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // mostly well-formed taps sized to the thresholds, some noise and long gaps
    task automatic run_phase(int budget);
        int start;
        int pt;
        int gt;
        int down_len;
        int up_len;
        int r;
        start = ticks_sent;
        pt = int'(scanner.thr.press_thr);
        gt = int'(scanner.thr.gap_thr);
        while (ticks_sent - start < budget)
        begin
            case ($urandom_range(0, 5))
                0: held_id = '0;
                1: held_id = 32'(8'($urandom_range(1, 255))) << (8 * $urandom_range(0, 3));
                2: ;
                default: held_id = $urandom;
            endcase
            if ($urandom_range(0, 3) != 0)
                down_len = pt + 1 + $urandom_range(0, 2);
            else
                down_len = $urandom_range(1, (pt > 5) ? 8 : pt + 3);
            r = $urandom_range(0, 7);
            if (r == 0 && gt <= 40)
                up_len = gt + 1 + $urandom_range(0, 2);
            else if (r == 1)
                up_len = $urandom_range(1, 12);
            else
                up_len = $urandom_range(1, (gt < 4) ? gt : 4);
            key_cycle(down_len, up_len);
        end
    endtask

    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : result_sink
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_stall ? 0 : idle_gap();
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        int rand_start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PRESS_THR;
        cfg_data = '0;
        in_valid = 1'b0;
        tick_drv = '0;
        held_id = '0;
        scanner = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // power-up hold clears the identity, then toggle, pairing and gap cases
        set_thresholds(8'd1, 8'd3, 3'd1, 8'd1, 4'd1);
        held_id = $urandom | 32'h1;
        key_cycle(6, 1);
        held_id = '0;
        key_cycle(2, 1);
        held_id = 32'hFFFF_FFFF;
        key_cycle(2, 1);
        key_cycle(2, 1);
        key_cycle(2, 5);
        key_cycle(2, 1);

        phase = 0;
        rand_start = ticks_sent;
        while (ticks_sent - rand_start < RANDOM_TICKS)
        begin
            case (phase)
                0: set_thresholds(8'd1, 8'd1, 3'd1, 8'd1, 4'd0);
                1: set_thresholds(8'd2, 8'd255, 3'd7, 8'd255, 4'd14);
                2: set_thresholds(8'd255, 8'($urandom_range(1, 20)), 3'($urandom_range(1, 7)),
                                  8'($urandom_range(1, 255)), 4'($urandom_range(0, 14)));
                default: set_thresholds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 20)),
                                        3'($urandom_range(1, 7)), 8'($urandom_range(1, 255)),
                                        4'($urandom_range(0, 14)));
            endcase
            no_stall = ($urandom_range(0, 3) == 0);
            run_phase(70);
            phase++;
        end

        no_stall = 1'b0;
        settle();
        repeat (4) @(negedge clk);
        $display("Run covered %0d scan ticks under %0d threshold settings.",
                 ticks_sent, settings_run);
        $display("Replies checked: %0d status, %0d pairing, %0d identity clear.",
                 scanner.status_due, scanner.pairing_due, scanner.clears_due);
        if (scanner.mismatches == 0 && scanner.due_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/btt_pkg.sv
sv/btt_cfg.sv
sv/btt_core.sv
sv/button_toggle_tap_pair_hold_reset.sv
tb/button_toggle_tap_pair_hold_reset_test.sv
